@@ design/upd_pkg.sv @@
`default_nettype none
package upd_pkg;

  // Character codes
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_SPACE   = 8'h20;

  // Group queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Results that one input byte can cause
  localparam int GRP_MAX = 3;
  localparam int GRP_CNT_W = $clog2(GRP_MAX + 1);

  // Escape tracking state
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_PCT  = 3'b010,
    ST_DIG  = 3'b100
  } upd_state_t;

  // Decoded bytes caused by one input byte
  typedef struct packed {
    logic [GRP_MAX-1:0][7:0] data;
    logic [GRP_CNT_W-1:0]    cnt;
    logic                    last;
  } upd_group_t;

  function automatic logic is_hex(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) ||
           (c >= 8'h41 && c <= 8'h46) ||
           (c >= 8'h61 && c <= 8'h66);
  endfunction

  // Value of a hex digit character (only meaningful when is_hex holds)
  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [3:0] v;
    if (c[6]) begin
      v = c[3:0] + 4'd9;
    end else begin
      v = c[3:0];
    end
    return v;
  endfunction

endpackage
`default_nettype wire

@@ design/upd_front.sv @@
`default_nettype none
module upd_front import upd_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_push,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_last,
  input  wire logic       q_full,
  output upd_group_t      grp,
  output logic            grp_vld
);

  upd_state_t st_r, st_nxt, idle_st;
  logic [7:0] dig_r, dig_nxt;
  logic       accept;
  logic       b_hex;
  logic       idle_emit;
  logic [7:0] idle_char;

  assign accept = in_push && !q_full;
  assign b_hex  = is_hex(in_byte);

  // Classify the byte as seen from the idle state
  assign idle_emit = !(in_byte == CH_PERCENT && !in_last);
  assign idle_char = (in_byte == CH_PLUS) ? CH_SPACE : in_byte;
  assign idle_st   = idle_emit ? ST_IDLE : ST_PCT;

  // Build the group of decoded bytes and the next escape state
  always_comb begin
    grp     = '0;
    st_nxt  = ST_IDLE;
    dig_nxt = dig_r;
    unique case (st_r)
      ST_PCT: begin
        if (b_hex) begin
          if (in_last) begin
            grp.data[0] = CH_PERCENT;
            grp.data[1] = in_byte;
            grp.cnt     = GRP_CNT_W'(2);
          end else begin
            dig_nxt = in_byte;
            st_nxt  = ST_DIG;
          end
        end else begin
          grp.data[0] = CH_PERCENT;
          grp.data[1] = idle_char;
          grp.cnt     = idle_emit ? GRP_CNT_W'(2) : GRP_CNT_W'(1);
          st_nxt      = idle_st;
        end
      end
      ST_DIG: begin
        if (b_hex) begin
          grp.data[0] = {hex_val(dig_r), hex_val(in_byte)};
          grp.cnt     = GRP_CNT_W'(1);
        end else begin
          grp.data[0] = CH_PERCENT;
          grp.data[1] = dig_r;
          grp.data[2] = idle_char;
          grp.cnt     = idle_emit ? GRP_CNT_W'(3) : GRP_CNT_W'(2);
          st_nxt      = idle_st;
        end
      end
      default: begin
        grp.data[0] = idle_char;
        grp.cnt     = idle_emit ? GRP_CNT_W'(1) : GRP_CNT_W'(0);
        st_nxt      = idle_st;
      end
    endcase
    // Drop any pending escape at the end of a message
    if (in_last) begin
      st_nxt = ST_IDLE;
    end
    grp.last = in_last;
  end

  assign grp_vld = accept && (grp.cnt != '0);

  // Advance escape state on each accepted request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= ST_IDLE;
      dig_r <= '0;
    end else if (accept) begin
      st_r  <= st_nxt;
      dig_r <= dig_nxt;
    end
  end

endmodule
`default_nettype wire

@@ design/upd_queue.sv @@
`default_nettype none
module upd_queue import upd_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic wr_en,
  input  wire upd_group_t wr_grp,
  input  wire logic rd_en,
  output upd_group_t rd_grp,
  output logic      q_full,
  output logic      q_empty
);

  upd_group_t          mem_r [QDEPTH];
  logic [QPTR_W-1:0]   wptr_r, rptr_r;
  logic [QCNT_W-1:0]   cnt_r;
  logic                do_wr, do_rd;

  assign q_full  = (cnt_r == QCNT_W'(QDEPTH));
  assign q_empty = (cnt_r == '0);
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && !q_empty;
  assign rd_grp  = mem_r[rptr_r];

  // Hold group payloads
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wptr_r] <= wr_grp;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (do_wr) begin
        wptr_r <= (wptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wptr_r + 1'b1;
      end
      if (do_rd) begin
        rptr_r <= (rptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rptr_r + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

@@ design/upd_back.sv @@
`default_nettype none
module upd_back import upd_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire upd_group_t q_grp,
  input  wire logic       q_empty,
  output logic            q_pop,
  input  wire logic       out_pop,
  output logic            out_empty,
  output logic [7:0]      out_byte,
  output logic            out_run_last,
  output logic            out_msg_end
);

  upd_group_t           cur_r;
  logic                 vld_r;
  logic [GRP_CNT_W-1:0] idx_r;
  logic                 take, at_end;

  assign at_end = (idx_r == cur_r.cnt - 1'b1);
  assign take   = out_pop && vld_r;
  assign q_pop  = (!vld_r || (take && at_end)) && !q_empty;

  // Select the current byte of the group
  always_comb begin
    unique case (idx_r)
      GRP_CNT_W'(1): out_byte = cur_r.data[1];
      GRP_CNT_W'(2): out_byte = cur_r.data[2];
      default:       out_byte = cur_r.data[0];
    endcase
  end

  assign out_empty    = !vld_r;
  assign out_run_last = at_end;
  assign out_msg_end  = at_end && cur_r.last;

  // Load the next group or step through the current one
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_grp;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      idx_r <= '0;
    end else if (q_pop) begin
      vld_r <= 1'b1;
      idx_r <= '0;
    end else if (take && at_end) begin
      vld_r <= 1'b0;
    end else if (take) begin
      idx_r <= idx_r + 1'b1;
    end
  end

endmodule
`default_nettype wire

@@ design/url_percent_decoder_unit.sv @@
`default_nettype none
// URL percent-decoder: one encoded byte in per cycle while in_full is low, one
// decoded byte out per cycle while out_pop is high and a result waits. An accepted
// input's results pass through the group queue and the output serialiser register.
// Throughput: one input and one output request per cycle when not stalled; a byte
// that expands to up to three results is drained by the serialiser at one byte per cycle.
// Reset (rst_n low, synchronous) clears the escape state and the group queue;
// out_empty is high and in_full low on the cycle after reset.
module url_percent_decoder_unit import upd_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_push,
  output logic            in_full,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_last,
  output logic            out_empty,
  input  wire logic       out_pop,
  output logic [7:0]      out_byte,
  output logic            out_run_last,
  output logic            out_msg_end
);

  upd_group_t f_grp, q_grp;
  logic       f_vld, q_full, q_empty, q_pop;

  assign in_full = q_full;

  upd_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_byte (in_byte),
    .in_last (in_last),
    .q_full  (q_full),
    .grp     (f_grp),
    .grp_vld (f_vld)
  );

  upd_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (f_vld),
    .wr_grp  (f_grp),
    .rd_en   (q_pop),
    .rd_grp  (q_grp),
    .q_full  (q_full),
    .q_empty (q_empty)
  );

  upd_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_grp        (q_grp),
    .q_empty      (q_empty),
    .q_pop        (q_pop),
    .out_pop      (out_pop),
    .out_empty    (out_empty),
    .out_byte     (out_byte),
    .out_run_last (out_run_last),
    .out_msg_end  (out_msg_end)
  );

endmodule
`default_nettype wire

@@ design/upd_checker.sv @@
`default_nettype none
module upd_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_full,
  input wire logic       out_empty,
  input wire logic       out_pop,
  input wire logic [7:0] out_byte,
  input wire logic       out_run_last,
  input wire logic       out_msg_end
);

  // Nothing waits and room is free right after reset
  a_empty_after_reset: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result queue not empty after reset");

  a_room_after_reset: assert property (@(posedge clk) !rst_n |=> !in_full)
    else $error("input full after reset");

  // End of message only on the last result of its input
  a_end_is_run_last: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_msg_end |-> out_run_last)
    else $error("msg_end without run_last");

  // Hold a waiting result until popped
  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_byte) &&
    $stable(out_run_last) && $stable(out_msg_end))
    else $error("waiting result changed");

endmodule

bind url_percent_decoder_unit upd_checker u_upd_checker (.*);
`default_nettype wire

@@ test/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import upd_pkg::*;

  // One decoded byte with its markers
  typedef struct packed {
    logic [7:0] data;
    logic       run_last;
    logic       msg_end;
  } decoded_t;

  // Decoder model and queue of decoded bytes still owed by the block
  class decoded_byte_board;
    upd_state_t  state;
    logic [7:0]  digit;
    decoded_t    group[$];
    decoded_t    owed[$];
    int          errors;

    function new();
      state  = ST_IDLE;
      digit  = 8'h00;
      errors = 0;
    endfunction

    // Classify a character as a hex digit and give its value
    static function bit hex_digit(input logic [7:0] c, output logic [3:0] v);
      v = 4'd0;
      if (c >= "0" && c <= "9") begin
        v = 4'(c - "0");
        return 1'b1;
      end
      if (c >= "A" && c <= "F") begin
        v = 4'(c - "A" + 8'd10);
        return 1'b1;
      end
      if (c >= "a" && c <= "f") begin
        v = 4'(c - "a" + 8'd10);
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function void emit(logic [7:0] b);
      decoded_t d;
      d.data     = b;
      d.run_last = 1'b0;
      d.msg_end  = 1'b0;
      group.push_back(d);
    endfunction

    // Handle one byte with no escape in progress
    function void plain_byte(logic [7:0] b, logic last);
      if (b == CH_PERCENT) begin
        if (last) begin
          emit(CH_PERCENT);
        end else begin
          state = ST_PCT;
        end
      end else if (b == CH_PLUS) begin
        emit(CH_SPACE);
      end else begin
        emit(b);
      end
    endfunction

    // Work out the decoded bytes caused by one accepted request
    function void note_encoded(logic [7:0] b, logic last);
      upd_state_t was;
      logic [3:0] lo, hi;
      bit         lo_ok, hi_ok;
      int         idx;
      was   = state;
      state = ST_IDLE;
      lo_ok = hex_digit(b, lo);
      group.delete();
      case (was)
        ST_PCT: begin
          if (lo_ok) begin
            if (last) begin
              emit(CH_PERCENT);
              emit(b);
            end else begin
              digit = b;
              state = ST_DIG;
            end
          end else begin
            emit(CH_PERCENT);
            plain_byte(b, last);
          end
        end
        ST_DIG: begin
          hi_ok = hex_digit(digit, hi);
          if (lo_ok && hi_ok) begin
            emit({hi, lo});
          end else begin
            // broken escape: flush '%' and the held digit, then redo this byte
            emit(CH_PERCENT);
            plain_byte(digit, 1'b0);
            plain_byte(b, last);
          end
        end
        default: begin
          plain_byte(b, last);
        end
      endcase
      if (last) begin
        state = ST_IDLE;
      end
      if (group.size() > 0) begin
        idx = group.size() - 1;
        group[idx].run_last = 1'b1;
        group[idx].msg_end  = last;
      end
      foreach (group[i]) begin
        owed.push_back(group[i]);
      end
    endfunction

    // Compare one popped result with the oldest owed byte
    function void check_decoded(logic [7:0] b, logic run_last, logic msg_end);
      decoded_t e;
      if (owed.size() == 0) begin
        $error("out_byte: no result expected, got %02h", b);
        errors++;
        return;
      end
      e = owed.pop_front();
      if (e.data !== b) begin
        $error("out_byte: expected %02h, got %02h", e.data, b);
        errors++;
      end
      if (e.run_last !== run_last) begin
        $error("out_run_last: expected %0b, got %0b", e.run_last, run_last);
        errors++;
      end
      if (e.msg_end !== msg_end) begin
        $error("out_msg_end: expected %0b, got %0b", e.msg_end, msg_end);
        errors++;
      end
    endfunction

    function int outstanding();
      return owed.size();
    endfunction
  endclass

  logic       clk;
  logic       rst_n;
  logic       in_push;
  logic       in_full;
  logic [7:0] in_byte;
  logic       in_last;
  logic       out_empty;
  logic       out_pop;
  logic [7:0] out_byte;
  logic       out_run_last;
  logic       out_msg_end;

  decoded_byte_board board;
  logic [7:0]        message[$];
  int                bytes_sent;
  bit                tx_gaps_on;
  bit                rx_gaps_on;

  url_percent_decoder_unit dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_full      (in_full),
    .in_byte      (in_byte),
    .in_last      (in_last),
    .out_empty    (out_empty),
    .out_pop      (out_pop),
    .out_byte     (out_byte),
    .out_run_last (out_run_last),
    .out_msg_end  (out_msg_end)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Push one encoded byte; push stays high unless a gap follows
  task automatic push_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = tx_gaps_on ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push <= 1'b1;
    in_byte <= b;
    in_last <= last;
    do @(posedge clk); while (in_full);
    board.note_encoded(b, last);
    bytes_sent++;
  endtask

  // Send the bytes held in message, flagging the final one
  task automatic send_message();
    tx_gaps_on = $urandom_range(0, 3) != 0;
    foreach (message[i]) begin
      push_byte(message[i], i == message.size() - 1);
    end
  endtask

  function automatic logic [7:0] hex_char();
    int r;
    r = $urandom_range(0, 21);
    if (r < 10) return 8'("0" + r);
    if (r < 16) return 8'("A" + r - 10);
    return 8'("a" + r - 16);
  endfunction

  function automatic logic [7:0] non_hex_char();
    logic [7:0] c;
    logic [3:0] v;
    do c = 8'($urandom_range(0, 255));
    while (decoded_byte_board::hex_digit(c, v));
    return c;
  endfunction

  // Well-formed escapes, with plus signs, noise and broken escapes
  task automatic build_random_message();
    int tokens;
    message.delete();
    tokens = $urandom_range(1, 5);
    repeat (tokens) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          message.push_back(CH_PERCENT);
          message.push_back(hex_char());
          message.push_back(hex_char());
        end
        4: begin
          message.push_back(CH_PLUS);
        end
        5: begin
          message.push_back(CH_PERCENT);
          if ($urandom_range(0, 1)) begin
            message.push_back(hex_char());
          end
          message.push_back(non_hex_char());
        end
        default: begin
          message.push_back(8'($urandom_range(0, 255)));
        end
      endcase
    end
    // cut some messages short so an escape is left pending at the end
    if (message.size() > 1 && $urandom_range(0, 5) == 0) begin
      void'(message.pop_back());
    end
  endtask

  // Result side: pop with random stalls, check each result
  initial begin
    int gap;
    out_pop    <= 1'b0;
    rx_gaps_on = 1'b1;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if ($urandom_range(0, 15) == 0) begin
        rx_gaps_on = !rx_gaps_on;
      end
      gap = rx_gaps_on ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
        out_pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_pop <= 1'b1;
      do @(posedge clk); while (out_empty);
      board.check_decoded(out_byte, out_run_last, out_msg_end);
    end
  end

  // Request side and end of run
  initial begin
    board      = new();
    bytes_sent = 0;
    tx_gaps_on = 1'b0;
    rst_n   <= 1'b0;
    in_push <= 1'b0;
    in_byte <= 8'h00;
    in_last <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed messages: escapes in both cases, plus, pending flushes, broken escapes
    message = {CH_PERCENT, "4", "a"};               send_message();
    message = {CH_PLUS};                            send_message();
    message = {CH_PERCENT};                         send_message();
    message = {CH_PERCENT, "4"};                    send_message();
    message = {CH_PERCENT, "4", "G"};               send_message();
    message = {CH_PERCENT, CH_PERCENT, "4", "1"};   send_message();
    message = {CH_PERCENT, "4", CH_PERCENT};        send_message();
    message = {CH_PERCENT, "F", "F"};               send_message();
    message = {CH_PERCENT, CH_PLUS};                send_message();
    message = {8'hFF, 8'h00};                       send_message();

    // Hold requests until the block has drained
    in_push <= 1'b0;
    while (board.outstanding() != 0) @(posedge clk);
    @(posedge clk);

    // Random messages
    while (bytes_sent < 95) begin
      build_random_message();
      send_message();
    end
    in_push <= 1'b0;

    while (board.outstanding() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (board.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Give up if the run stalls
  initial begin
    #2000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

@@ url_percent_decoder_unit.f @@
design/upd_pkg.sv
design/upd_front.sv
design/upd_queue.sv
design/upd_back.sv
design/url_percent_decoder_unit.sv
design/upd_checker.sv
test/testbench.sv
